[hdl/bmp_rgb24_stream_writer_unit_defines.svh]
// ----------------------------------------------------------------------------
// BMP stream writer assertion macros
// Shared property shorthands for the checker of the BMP stream writer.
// ----------------------------------------------------------------------------
`ifndef BMP_RGB24_STREAM_WRITER_UNIT_DEFINES_SVH
`define BMP_RGB24_STREAM_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BMPW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmpw: property violated");

// Next-cycle implication, disabled while reset is low.
`define BMPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmpw: property violated");

`endif

[hdl/bmpw_pkg.sv]
// ----------------------------------------------------------------------------
// BMP stream writer package
// Widths, header constants, queue item type and header byte lookup.
// ----------------------------------------------------------------------------
package bmpw_pkg;

  localparam int unsigned DIM_W       = 13;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned W_RESET     = 640;
  localparam int unsigned H_RESET     = 480;
  localparam int unsigned HDR_BYTES   = 54;
  localparam int unsigned HDR_IDX_W   = 6;
  localparam int unsigned ROW_BYTES_W = 14;
  localparam int unsigned RAW_W       = ROW_BYTES_W + DIM_W;
  localparam int unsigned Q_DEPTH     = 4;
  localparam int unsigned Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W     = Q_PTR_W + 1;

  localparam int unsigned DIB_BYTES   = 40;
  localparam int unsigned PELS_PER_M  = 2835;
  localparam int unsigned BITS_PER_PEL = 24;
  localparam int unsigned PLANES      = 1;
  localparam logic [7:0]  BYTE_MASK   = 8'hFF;
  localparam logic [7:0]  CHAR_B      = 8'h42;
  localparam logic [7:0]  CHAR_M      = 8'h4D;

  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       hdr;
    logic       row_end;
    logic       frame_end;
  } bmpw_item_t;

  // Clamp a dimension register into 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Header byte at position idx: two tag bytes, then thirteen little-endian words.
  function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                          input logic [DIM_W-1:0]     w,
                                          input logic [DIM_W-1:0]     h,
                                          input logic [RAW_W-1:0]     raw);
    logic [HDR_IDX_W-1:0] ofs;
    logic [3:0]           word;
    logic [1:0]           lane;
    logic [31:0]          val;
    logic [7:0]           b;
    ofs  = idx - HDR_IDX_W'(2);
    word = ofs[5:2];
    lane = ofs[1:0];
    case (word)
      4'd0:    val = 32'(raw) + 32'(HDR_BYTES);
      4'd2:    val = 32'(HDR_BYTES);
      4'd3:    val = 32'(DIB_BYTES);
      4'd4:    val = 32'(w);
      4'd5:    val = 32'(h);
      4'd6:    val = (32'(BITS_PER_PEL) << 16) | 32'(PLANES);
      4'd8:    val = 32'(raw);
      4'd9:    val = 32'(PELS_PER_M);
      4'd10:   val = 32'(PELS_PER_M);
      default: val = '0;
    endcase
    b = 8'(val >> {lane, 3'b000}) & BYTE_MASK;
    if (idx == HDR_IDX_W'(0)) begin
      b = CHAR_B;
    end else if (idx == HDR_IDX_W'(1)) begin
      b = CHAR_M;
    end
    return b;
  endfunction

endpackage

[hdl/bmpw_if.sv]
// ----------------------------------------------------------------------------
// BMP stream writer channels
// Pixel input channel and file byte output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmpw_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface bmpw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       file_end;

  modport source (output valid, output out_byte, output last_of_run, output file_end,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input file_end,
                  output ready);
endinterface

[hdl/bmpw_queue.sv]
// ----------------------------------------------------------------------------
// BMP stream writer item queue
// Four-entry FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
module bmpw_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bmpw_pkg::bmpw_item_t item_i,
  input  logic                pop_i,
  output bmpw_pkg::bmpw_item_t head_o,
  output logic                empty_o,
  output logic                full_o
);

  bmpw_pkg::bmpw_item_t              mem_q [bmpw_pkg::Q_DEPTH];
  logic [bmpw_pkg::Q_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [bmpw_pkg::Q_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [bmpw_pkg::Q_CNT_W-1:0]     cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == bmpw_pkg::Q_CNT_W'(bmpw_pkg::Q_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hdl/bmpw_front.sv]
// ----------------------------------------------------------------------------
// BMP stream writer front end
// Accept pixels, track column and row, tag header, row end and frame end.
// ----------------------------------------------------------------------------
module bmpw_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bmpw_pkg::DIM_W-1:0]   w_eff_i,
  input  logic [bmpw_pkg::DIM_W-1:0]   h_eff_i,
  bmpw_pix_if.sink                     pix_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output bmpw_pkg::bmpw_item_t         item_o
);

  logic [bmpw_pkg::POS_W-1:0] col_q, col_d;
  logic [bmpw_pkg::POS_W-1:0] row_q, row_d;
  logic [bmpw_pkg::DIM_W-1:0] col_inc, row_inc;
  logic                       row_end, frame_end;

  assign pix_i.ready = !q_full_i;
  assign push_o      = pix_i.valid && !q_full_i;

  // A counter at or past the last position counts as on it.
  assign col_inc   = {1'b0, col_q} + 1'b1;
  assign row_inc   = {1'b0, row_q} + 1'b1;
  assign row_end   = (col_inc >= w_eff_i);
  assign frame_end = row_end && (row_inc >= h_eff_i);

  always_comb begin
    item_o.red       = pix_i.red;
    item_o.green     = pix_i.green;
    item_o.blue      = pix_i.blue;
    item_o.hdr       = (col_q == '0) && (row_q == '0);
    item_o.row_end   = row_end;
    item_o.frame_end = frame_end;

    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_inc[bmpw_pkg::POS_W-1:0];
      end else begin
        col_d = col_inc[bmpw_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

[hdl/bmpw_back.sv]
// ----------------------------------------------------------------------------
// BMP stream writer back end
// Expand each queued pixel into header, pixel and pad bytes, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module bmpw_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bmpw_pkg::DIM_W-1:0]   w_eff_i,
  input  logic [bmpw_pkg::DIM_W-1:0]   h_eff_i,
  input  bmpw_pkg::bmpw_item_t         head_i,
  input  logic                         q_empty_i,
  output logic                         pop_o,
  bmpw_byte_if.source                  bytes_o
);

  typedef enum logic [1:0] {
    S_START,
    S_HDR,
    S_PIX,
    S_PAD
  } state_e;

  state_e                              state_q, state_d, cur_ph;
  logic [bmpw_pkg::HDR_IDX_W-1:0]      idx_q, idx_d, cur_idx;
  logic [1:0]                          pad;
  logic [bmpw_pkg::ROW_BYTES_W-1:0]    row_bytes_q;
  logic [bmpw_pkg::DIM_W-1:0]          h_q;
  logic [bmpw_pkg::RAW_W-1:0]          raw_q;
  logic                                adv, last;
  logic [7:0]                          byte_b;
  logic                                out_valid_q;
  logic [7:0]                          out_byte_q;
  logic                                out_last_q, out_fend_q;

  assign pad = w_eff_i[1:0];

  // Sizes for the header: row bytes, then raw size in the cycle after.
  always_ff @(posedge clk_i) begin
    row_bytes_q <= bmpw_pkg::ROW_BYTES_W'({w_eff_i, 1'b0}) +
                   bmpw_pkg::ROW_BYTES_W'(w_eff_i) + bmpw_pkg::ROW_BYTES_W'(pad);
    h_q         <= h_eff_i;
    raw_q       <= bmpw_pkg::RAW_W'(row_bytes_q) * bmpw_pkg::RAW_W'(h_q);
  end

  assign adv   = !q_empty_i && (!out_valid_q || bytes_o.ready);
  assign pop_o = adv && last;

  always_comb begin
    cur_ph  = state_q;
    cur_idx = idx_q;
    if (state_q == S_START) begin
      cur_ph  = head_i.hdr ? S_HDR : S_PIX;
      cur_idx = '0;
    end
    byte_b  = '0;
    last    = 1'b0;
    state_d = state_q;
    idx_d   = idx_q;
    unique case (cur_ph)
      S_HDR: begin
        byte_b = bmpw_pkg::hdr_byte(cur_idx, w_eff_i, h_q, raw_q);
        if (cur_idx == bmpw_pkg::HDR_IDX_W'(bmpw_pkg::HDR_BYTES - 1)) begin
          state_d = S_PIX;
          idx_d   = '0;
        end else begin
          state_d = S_HDR;
          idx_d   = cur_idx + 1'b1;
        end
      end
      S_PIX: begin
        // Bytes go out blue, green, red.
        unique case (cur_idx[1:0])
          2'd0:    byte_b = head_i.blue;
          2'd1:    byte_b = head_i.green;
          default: byte_b = head_i.red;
        endcase
        if (cur_idx == bmpw_pkg::HDR_IDX_W'(2)) begin
          idx_d = '0;
          if (head_i.row_end && pad != 2'd0) begin
            state_d = S_PAD;
          end else begin
            state_d = S_START;
            last    = 1'b1;
          end
        end else begin
          state_d = S_PIX;
          idx_d   = cur_idx + 1'b1;
        end
      end
      S_PAD: begin
        if (cur_idx == {4'b0000, pad - 2'd1}) begin
          state_d = S_START;
          idx_d   = '0;
          last    = 1'b1;
        end else begin
          state_d = S_PAD;
          idx_d   = cur_idx + 1'b1;
        end
      end
      default: begin
        state_d = S_START;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_START;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
      out_fend_q  <= 1'b0;
    end else begin
      if (adv) begin
        state_q     <= state_d;
        idx_q       <= idx_d;
        out_valid_q <= 1'b1;
        out_byte_q  <= byte_b;
        out_last_q  <= last;
        out_fend_q  <= last && head_i.frame_end;
      end else if (bytes_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign bytes_o.valid       = out_valid_q;
  assign bytes_o.out_byte    = out_byte_q;
  assign bytes_o.last_of_run = out_last_q;
  assign bytes_o.file_end    = out_fend_q;

endmodule

[hdl/bmp_rgb24_stream_writer_unit.sv]
// ----------------------------------------------------------------------------
// BMP RGB24 stream writer
// Turns a stream of RGB pixels into the byte stream of a 24-bit BMP file.
// ----------------------------------------------------------------------------
// Feed pixels row by row, bottom row first; bytes leave the output register
// one per cycle unless it stalls or the queue is empty. A pixel gives 3 bytes
// (blue, green, red), the first pixel of a frame adds 54 header bytes, the
// last of each row (width mod 4) pad bytes; a frame is 54 + height * (3 *
// width + (width mod 4)) bytes. A front end accepts pixels into a four-deep
// queue, so input keeps flowing while the back end drains header or pad
// bytes. Width and height are clamped to 1..4096; write them only while the
// block is idle. last_of_run marks each pixel's final byte and file_end the
// final byte of the file; the next pixel after that opens a new file.
module bmp_rgb24_stream_writer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bmpw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bmpw_pkg::DIM_W-1:0]       cfg_data_i,
  bmpw_pix_if.sink                         pix_i,
  bmpw_byte_if.source                      bytes_o
);

  logic [bmpw_pkg::DIM_W-1:0] width_q, height_q;
  logic [bmpw_pkg::DIM_W-1:0] w_eff, h_eff;
  logic                       push, pop, q_full, q_empty;
  bmpw_pkg::bmpw_item_t       push_item, head_item;

  // Hold the raw register values; clamp on the way out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bmpw_pkg::DIM_W'(bmpw_pkg::W_RESET);
      height_q <= bmpw_pkg::DIM_W'(bmpw_pkg::H_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmpw_pkg::CFG_IDX_WIDTH:  width_q  <= cfg_data_i;
        bmpw_pkg::CFG_IDX_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff = bmpw_pkg::eff_dim(width_q);
  assign h_eff = bmpw_pkg::eff_dim(height_q);

  // Front: count position and tag each pixel.
  bmpw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .w_eff_i  (w_eff),
    .h_eff_i  (h_eff),
    .pix_i    (pix_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item)
  );

  // Queue: decouple pixel intake from byte output.
  bmpw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back: emit header, pixel and pad bytes through the output register.
  bmpw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .w_eff_i   (w_eff),
    .h_eff_i   (h_eff),
    .head_i    (head_item),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .bytes_o   (bytes_o)
  );

endmodule

[hdl/bmpw_checker.sv]
// ----------------------------------------------------------------------------
// BMP stream writer port checker
// Port-level properties of the stream writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "bmp_rgb24_stream_writer_unit_defines.svh"

module bmpw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i,
  input logic       out_fend_i
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_i;

  // A stalled byte holds.
  `BMPW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i))

  // The file end is always a pixel's final byte.
  `BMPW_ASSERT_SAME(a_fend_last, clk_i, rst_ni, out_valid_i && out_fend_i, out_last_i)

  // After an accepted pixel has gone through the queue and the output register, a byte is valid.
  `BMPW_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_xfer, ##1 out_valid_i)

endmodule

bind bmp_rgb24_stream_writer_unit bmpw_checker u_bmpw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (bytes_o.valid),
  .out_ready_i (bytes_o.ready),
  .out_byte_i  (bytes_o.out_byte),
  .out_last_i  (bytes_o.last_of_run),
  .out_fend_i  (bytes_o.file_end)
);
